[hdl/six_channel_bidirectional_pwm_assert.svh]
// Assertion macros for the six-channel bidirectional PWM.
// Included by the RTL files that check their own logic; needs no package.
`ifndef SIX_CHANNEL_BIDIRECTIONAL_PWM_ASSERT_SVH
`define SIX_CHANNEL_BIDIRECTIONAL_PWM_ASSERT_SVH
`ifndef SYNTHESIS
// Condition that must hold in the same cycle as the trigger.
`define SCBPWM_ASSERT_SAME(label, clk, rstn, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (cond)) \
        else $error(msg);
// Condition that must hold in the cycle after the trigger.
`define SCBPWM_ASSERT_NEXT(label, clk, rstn, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
        else $error(msg);
`else
`define SCBPWM_ASSERT_SAME(label, clk, rstn, trig, cond, msg)
`define SCBPWM_ASSERT_NEXT(label, clk, rstn, trig, cond, msg)
`endif
`endif

[hdl/scbpwm_pkg.sv]
// Shared types, constants and helpers of the six-channel bidirectional PWM.
// No dependencies; imported by every module of the block.
`default_nettype none
package scbpwm_pkg;
    localparam int LANES        = 6;
    localparam int NUM_CHANNELS = 6;
    localparam int FULL_SCALE   = 100;
    localparam int DUTY_W       = 8;
    localparam int MAG_W        = 7;
    localparam int PHASE_W      = 16;
    localparam int LEVEL_W      = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    // per * |duty| and 100 * (phase + 1) both stay below 2^23
    localparam int PROD_W       = 23;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = CFG_IDX_W'(1);

    localparam logic [PHASE_W-1:0] PERIOD_RESET    = PHASE_W'(100);
    localparam logic [LEVEL_W-1:0] AMPLITUDE_RESET = LEVEL_W'(1);

    typedef logic signed [DUTY_W-1:0] duty_t;
    typedef logic [MAG_W-1:0]         mag_t;
    typedef logic [PHASE_W-1:0]       phase_t;
    typedef logic [LEVEL_W-1:0]       level_t;
    typedef logic [PROD_W-1:0]        prod_t;

    typedef struct packed {
        logic latch_en;  // accepted tick sits at phase zero
        logic s1_load;   // tick enters the multiply stage
        logic out_load;  // multiply stage moves to the output register
    } lane_ctrl_t;

    function automatic duty_t clamp_duty(input duty_t d);
        duty_t r;
        if (d > duty_t'(FULL_SCALE)) begin
            r = duty_t'(FULL_SCALE);
        end else if (d < -duty_t'(FULL_SCALE)) begin
            r = -duty_t'(FULL_SCALE);
        end else begin
            r = d;
        end
        return r;
    endfunction

    // Magnitude of a clamped duty, at most 100.
    function automatic mag_t duty_mag(input duty_t d);
        duty_t a;
        a = d[DUTY_W-1] ? -d : d;
        return a[MAG_W-1:0];
    endfunction
endpackage
`default_nettype wire

[hdl/scbpwm_seq.sv]
// Phase counter and pipeline control of the six-channel bidirectional PWM.
// Uses scbpwm_pkg and the assertion macros in six_channel_bidirectional_pwm_assert.svh.
`default_nettype none
`include "six_channel_bidirectional_pwm_assert.svh"
module scbpwm_seq (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire scbpwm_pkg::phase_t   period,
    output scbpwm_pkg::phase_t        per_eff,
    output scbpwm_pkg::prod_t         thr,
    output scbpwm_pkg::lane_ctrl_t    ctrl
);
    import scbpwm_pkg::*;

    phase_t               phase_reg, phase_next;
    phase_t               phase_cur;
    logic [PHASE_W:0]     phase_inc;
    prod_t                thr_reg, thr_next;
    logic                 s1_valid_reg, s1_valid_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 accept, out_en;

    assign per_eff   = (period == '0) ? phase_t'(1) : period;
    // restart the phase if the period shrank below it
    assign phase_cur = (phase_reg >= per_eff) ? '0 : phase_reg;
    assign phase_inc = {1'b0, phase_cur} + (PHASE_W+1)'(1);

    assign out_en  = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || out_en;
    assign accept  = s_valid && s_ready;

    assign ctrl.latch_en = accept && (phase_cur == '0);
    assign ctrl.s1_load  = accept;
    assign ctrl.out_load = s1_valid_reg && out_en;

    // phase < floor(per*mag/100) is the same as 100*(phase+1) <= per*mag
    assign thr_next = prod_t'(phase_inc) * prod_t'(FULL_SCALE);

    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            phase_next = (phase_inc >= {1'b0, per_eff}) ? '0 : phase_inc[PHASE_W-1:0];
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (out_en) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (ctrl.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            thr_reg <= thr_next;
        end
    end

    assign thr     = thr_reg;
    assign m_valid = m_valid_reg;

    `SCBPWM_ASSERT_NEXT(a_accept_fills_s1, aclk, aresetn, accept, s1_valid_reg, "accepted tick lost before the multiply stage")
    `SCBPWM_ASSERT_NEXT(a_move_fills_out, aclk, aresetn, ctrl.out_load, m_valid_reg, "tick lost between multiply stage and output")
    `SCBPWM_ASSERT_SAME(a_empty_is_ready, aclk, aresetn, !s1_valid_reg, s_ready, "input stalled with an empty pipeline")
    `SCBPWM_ASSERT_NEXT(a_phase_in_range, aclk, aresetn, accept, phase_reg != '1, "phase counter left its range")
endmodule
`default_nettype wire

[hdl/scbpwm_lane.sv]
// One PWM lane: duty latch, width multiply stage and compare/output register.
// Uses scbpwm_pkg; driven by the control struct from scbpwm_seq.
`default_nettype none
module scbpwm_lane (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire scbpwm_pkg::lane_ctrl_t ctrl,
    input  wire scbpwm_pkg::duty_t    duty_in,
    input  wire scbpwm_pkg::phase_t   per_eff,
    input  wire scbpwm_pkg::prod_t    thr,
    input  wire scbpwm_pkg::level_t   amplitude,
    output scbpwm_pkg::level_t        fwd,
    output scbpwm_pkg::level_t        rev
);
    import scbpwm_pkg::*;

    duty_t   latched_reg;
    duty_t   duty_eff;
    prod_t   prod_reg;
    logic    pos_reg, neg_reg;
    level_t  fwd_reg, fwd_next;
    level_t  rev_reg, rev_next;
    logic    pulse_on;

    // a tick at phase zero uses its own clamped duty
    assign duty_eff = ctrl.latch_en ? clamp_duty(duty_in) : latched_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latched_reg <= '0;
        end else if (ctrl.latch_en) begin
            latched_reg <= clamp_duty(duty_in);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.s1_load) begin
            prod_reg <= prod_t'(per_eff) * prod_t'(duty_mag(duty_eff));
            pos_reg  <= !duty_eff[DUTY_W-1] && (duty_eff != '0);
            neg_reg  <= duty_eff[DUTY_W-1];
        end
    end

    assign pulse_on = (thr <= prod_reg);
    assign fwd_next = (pos_reg && pulse_on) ? amplitude : '0;
    assign rev_next = (neg_reg && pulse_on) ? amplitude : '0;

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            fwd_reg <= fwd_next;
            rev_reg <= rev_next;
        end
    end

    assign fwd = fwd_reg;
    assign rev = rev_reg;
endmodule
`default_nettype wire

[hdl/six_channel_bidirectional_pwm.sv]
// Top level of the six-channel bidirectional PWM: configuration registers,
// lanes and output merge. Uses scbpwm_pkg, scbpwm_seq and scbpwm_lane.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------
//   input    | s_valid / s_ready  | s_duty_a .. s_duty_f, one tick
//   result   | m_valid / m_ready  | m_fwd_a, m_rev_a .. m_fwd_f, m_rev_f
//   config   | cfg_wr_en          | cfg_index, cfg_wr_data
//
// One tick per clock while s_ready is high; a result passes the multiply
// stage, then the compare into the output register, before it is valid.
// The phase counter is shared by all lanes.
// Reset clears the phase and latched duties and loads period 100, amplitude 1.
// A stalled result holds the output register; the input stalls only when
// both pipeline stages are full.
`default_nettype none
module six_channel_bidirectional_pwm (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [scbpwm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [scbpwm_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire scbpwm_pkg::duty_t                   s_duty_a,
    input  wire scbpwm_pkg::duty_t                   s_duty_b,
    input  wire scbpwm_pkg::duty_t                   s_duty_c,
    input  wire scbpwm_pkg::duty_t                   s_duty_d,
    input  wire scbpwm_pkg::duty_t                   s_duty_e,
    input  wire scbpwm_pkg::duty_t                   s_duty_f,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output scbpwm_pkg::level_t                       m_fwd_a,
    output scbpwm_pkg::level_t                       m_rev_a,
    output scbpwm_pkg::level_t                       m_fwd_b,
    output scbpwm_pkg::level_t                       m_rev_b,
    output scbpwm_pkg::level_t                       m_fwd_c,
    output scbpwm_pkg::level_t                       m_rev_c,
    output scbpwm_pkg::level_t                       m_fwd_d,
    output scbpwm_pkg::level_t                       m_rev_d,
    output scbpwm_pkg::level_t                       m_fwd_e,
    output scbpwm_pkg::level_t                       m_rev_e,
    output scbpwm_pkg::level_t                       m_fwd_f,
    output scbpwm_pkg::level_t                       m_rev_f
);
    import scbpwm_pkg::*;

    phase_t      period_reg;
    level_t      amplitude_reg;
    phase_t      per_eff;
    prod_t       thr;
    lane_ctrl_t  ctrl;
    duty_t       duty_in [LANES];
    level_t      fwd [LANES];
    level_t      rev [LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= PERIOD_RESET;
            amplitude_reg <= AMPLITUDE_RESET;
        end else if (cfg_wr_en) begin
            // drop writes to unknown indexes
            unique case (cfg_index)
                REG_PERIOD:    period_reg    <= cfg_wr_data;
                REG_AMPLITUDE: amplitude_reg <= cfg_wr_data;
                default:       ;
            endcase
        end
    end

    scbpwm_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .period   (period_reg),
        .per_eff  (per_eff),
        .thr      (thr),
        .ctrl     (ctrl)
    );

    assign duty_in[0] = s_duty_a;
    assign duty_in[1] = s_duty_b;
    assign duty_in[2] = s_duty_c;
    assign duty_in[3] = s_duty_d;
    assign duty_in[4] = s_duty_e;
    assign duty_in[5] = s_duty_f;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        if (i < NUM_CHANNELS) begin : g_on
            scbpwm_lane u_lane (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .duty_in   (duty_in[i]),
                .per_eff   (per_eff),
                .thr       (thr),
                .amplitude (amplitude_reg),
                .fwd       (fwd[i]),
                .rev       (rev[i])
            );
        end else begin : g_off
            assign fwd[i] = '0;
            assign rev[i] = '0;
        end
    end

    assign m_fwd_a = fwd[0];
    assign m_rev_a = rev[0];
    assign m_fwd_b = fwd[1];
    assign m_rev_b = rev[1];
    assign m_fwd_c = fwd[2];
    assign m_rev_c = rev[2];
    assign m_fwd_d = fwd[3];
    assign m_rev_d = rev[3];
    assign m_fwd_e = fwd[4];
    assign m_rev_e = rev[4];
    assign m_fwd_f = fwd[5];
    assign m_rev_f = rev[5];
endmodule
`default_nettype wire
